// ----- rtl/core/vrlos_pkg.sv -----
package vrlos_pkg;

    // operation codes of an input beat
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture beat fields, start walk setup
        logic wr_mem;     // write occupancy bit of start voxel
        logic probe_rd;   // issue read for current probe
        logic probe_next; // advance probe index
        logic walk_step;  // step the ray one cell
        logic clr_wr;     // write zero at clear address
        logic clr_next;   // advance clear address
        logic res_load;   // load result register
        logic res_blk;    // blocked value for result
        logic res_qry;    // was_query value for result
    } vrlos_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_query;
        logic same_ends;   // start equals end
        logic at_end;      // current cell is end cell
        logic probe_last;  // current probe is last of the tube
        logic probe_hit;   // registered read data with in-grid flag
        logic clr_done;    // clear sweep at last address
    } vrlos_sts_t;

endpackage

// ----- rtl/core/vrlos_ram.sv -----
module vrlos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/vrlos_dp.sv -----
module vrlos_dp #(
    parameter int COORD_BITS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vrlos_pkg::vrlos_cmd_t cmd,
    output vrlos_pkg::vrlos_sts_t sts,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] start_z,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] end_z,
    input  logic                  occupied,
    input  logic [1:0]            margin_val,
    output logic                  m_blocked,
    output logic                  m_was_query
);

    localparam int CB = COORD_BITS;
    localparam int AB = 3 * CB;
    localparam int CW = CB + 1;          // step count width
    localparam int PW = 2 * CB + 3;      // cross product width
    localparam int SW = CB + 3;          // signed probe coordinate width

    typedef logic [CB-1:0] crd_t;

    crd_t cur_reg [3];
    crd_t end_reg [3];
    logic [CB-1:0] mag_reg [3];
    logic [CW-1:0] cnt_reg [3];
    logic          neg_reg [3];
    logic          query_reg;
    logic          occ_reg;
    logic [2:0]    dist_reg;             // probe distance 0..margin
    logic [2:0]    sel_reg;              // axis*2+sign for neighbour probes
    logic          inb_reg;              // probe in grid, aligned with read data
    logic [AB-1:0] clr_reg;
    logic [AB-1:0] rd_addr;
    logic [AB-1:0] wr_addr;
    logic          wr_en;
    logic          rd_bit;
    logic          blk_reg;
    logic          wq_reg;
    logic [1:0]    margin_lat;

    crd_t in_s [3];
    crd_t in_e [3];
    assign in_s[0] = start_x;
    assign in_s[1] = start_y;
    assign in_s[2] = start_z;
    assign in_e[0] = end_x;
    assign in_e[1] = end_y;
    assign in_e[2] = end_z;

    // tube probe coordinate
    logic signed [SW-1:0] pc [3];
    logic                 p_in;
    logic [1:0]           p_ax;
    logic                 p_neg;
    always_comb begin
        p_ax  = sel_reg[2:1];
        p_neg = sel_reg[0];
        p_in  = 1'b1;
        for (int a = 0; a < 3; a++) begin
            pc[a] = $signed({3'b000, cur_reg[a]});
            if (dist_reg != 3'd0 && p_ax == 2'(a)) begin
                if (p_neg) pc[a] = pc[a] - $signed({{(SW-3){1'b0}}, dist_reg});
                else       pc[a] = pc[a] + $signed({{(SW-3){1'b0}}, dist_reg});
            end
            if (pc[a] < 0 || pc[a] > $signed(SW'((1 << CB) - 1))) p_in = 1'b0;
        end
        rd_addr = {pc[2][CB-1:0], pc[1][CB-1:0], pc[0][CB-1:0]};
    end

    // probe bookkeeping: end cell is probed alone
    logic cur_at_end;
    always_comb begin
        cur_at_end = (cur_reg[0] == end_reg[0]) && (cur_reg[1] == end_reg[1])
                   && (cur_reg[2] == end_reg[2]);
    end

    // boundary comparisons as cross products
    logic [PW-1:0] lhs_xy, rhs_xy, lhs_xz, rhs_xz, lhs_yz, rhs_yz;
    logic lt_xy, lt_xz, lt_yz;
    logic [1:0] step_ax;
    function automatic logic [PW-1:0] xprod(logic [CW-1:0] c, logic [CB-1:0] m);
        logic [CW:0] o;
        begin
            o = {c, 1'b1};
            xprod = PW'(o) * PW'(m);
        end
    endfunction
    always_comb begin
        lhs_xy = xprod(cnt_reg[0], mag_reg[1]);
        rhs_xy = xprod(cnt_reg[1], mag_reg[0]);
        lhs_xz = xprod(cnt_reg[0], mag_reg[2]);
        rhs_xz = xprod(cnt_reg[2], mag_reg[0]);
        lhs_yz = xprod(cnt_reg[1], mag_reg[2]);
        rhs_yz = xprod(cnt_reg[2], mag_reg[1]);
        lt_xy = (mag_reg[0] != '0) && ((mag_reg[1] == '0) || (lhs_xy < rhs_xy));
        lt_xz = (mag_reg[0] != '0) && ((mag_reg[2] == '0) || (lhs_xz < rhs_xz));
        lt_yz = (mag_reg[1] != '0) && ((mag_reg[2] == '0) || (lhs_yz < rhs_yz));
        if (lt_xy) step_ax = lt_xz ? 2'd0 : 2'd2;
        else       step_ax = lt_yz ? 2'd1 : 2'd2;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            dist_reg <= '0;
            sel_reg  <= '0;
            blk_reg  <= 1'b0;
            wq_reg   <= 1'b0;
        end else begin
            if (cmd.clr_next) clr_reg <= clr_reg + AB'(1);
            if (cmd.load) begin
                query_reg  <= operation;
                occ_reg    <= occupied;
                margin_lat <= margin_val;
                dist_reg   <= '0;
                sel_reg    <= '0;
                for (int a = 0; a < 3; a++) begin
                    cur_reg[a] <= in_s[a];
                    end_reg[a] <= in_e[a];
                    neg_reg[a] <= in_e[a] < in_s[a];
                    mag_reg[a] <= (in_e[a] < in_s[a]) ? in_s[a] - in_e[a]
                                                      : in_e[a] - in_s[a];
                    cnt_reg[a] <= '0;
                end
            end
            if (cmd.probe_rd) inb_reg <= p_in;
            if (cmd.probe_next) begin
                if (sel_reg == 3'd5 || dist_reg == 3'd0) begin
                    sel_reg  <= '0;
                    dist_reg <= dist_reg + 3'd1;
                end else begin
                    sel_reg <= sel_reg + 3'd1;
                end
            end
            if (cmd.walk_step) begin
                dist_reg <= '0;
                sel_reg  <= '0;
                for (int a = 0; a < 3; a++) begin
                    if (step_ax == 2'(a)) begin
                        cur_reg[a] <= neg_reg[a] ? cur_reg[a] - crd_t'(1)
                                                 : cur_reg[a] + crd_t'(1);
                        cnt_reg[a] <= cnt_reg[a] + CW'(1);
                    end
                end
            end
            if (cmd.res_load) begin
                blk_reg <= cmd.res_blk;
                wq_reg  <= cmd.res_qry;
            end
        end
    end

    // occupancy memory port selection
    always_comb begin
        wr_en   = cmd.clr_wr | cmd.wr_mem;
        wr_addr = cmd.clr_wr ? clr_reg : {cur_reg[2], cur_reg[1], cur_reg[0]};
    end

    vrlos_ram #(.WIDTH(1), .DEPTH(1 << AB)) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.clr_wr ? 1'b0 : occ_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_bit)
    );

    // status back to the controller
    always_comb begin
        sts.is_query   = query_reg;
        sts.same_ends  = cur_at_end;
        sts.at_end     = cur_at_end;
        sts.probe_last = cur_at_end ||
                         (dist_reg == {1'b0, margin_lat} &&
                          (dist_reg == 3'd0 || sel_reg == 3'd5));
        sts.probe_hit  = rd_bit & inb_reg;
        sts.clr_done   = (clr_reg == '1);
    end

    assign m_blocked   = blk_reg;
    assign m_was_query = wq_reg;

endmodule

// ----- rtl/core/vrlos_ctrl.sv -----
module vrlos_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vrlos_pkg::vrlos_cmd_t cmd,
    input  vrlos_pkg::vrlos_sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_ISSUE, ST_CHECK, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   end_reg, end_next;     // issued probe was at the end cell
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        end_next     = end_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr   = 1'b1;
                cmd.clr_next = 1'b1;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.is_query) begin
                    cmd.wr_mem = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.same_ends) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ISSUE;
                end
                cmd.res_load = 1'b1;
                cmd.res_qry  = sts.is_query;
                cmd.res_blk  = 1'b0;
            end
            ST_ISSUE: begin
                cmd.probe_rd   = 1'b1;
                end_next       = sts.at_end;
                if (sts.probe_last) begin
                    if (!sts.at_end) cmd.walk_step = 1'b1;
                end else begin
                    cmd.probe_next = 1'b1;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.probe_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_qry  = 1'b1;
                    cmd.res_blk  = 1'b1;
                    state_next   = ST_DONE;
                end else if (end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            end_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            end_reg     <= end_next;
        end
    end

endmodule

// ----- rtl/core/voxel_ray_line_of_sight_top.sv -----
// channel | handshake          | payload
// s_      | s_valid / s_ready  | operation, start_x/y/z, end_x/y/z, occupied
// m_      | m_valid / m_ready  | blocked, was_query
// cfg     | cfg_we, no wait    | cfg_data (tube margin)
//
// write beat: decode, then done. query: an issue and a check state per probe;
// a walked cell takes 1 + 6*margin probes, the end cell one, through the single
// read port of the occupancy memory.
// a query stops probing at the first hit.
// after reset a clear sweep over all 2^(3*COORD_BITS) addresses (32768) runs first.
// one beat is in work at a time; a held result stalls only the next beat.
module voxel_ray_line_of_sight_top #(
    parameter int COORD_BITS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_start_z,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [COORD_BITS-1:0] s_end_z,
    input  logic                  s_occupied,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_blocked,
    output logic                  m_was_query,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_data
);

    vrlos_pkg::vrlos_cmd_t cmd;
    vrlos_pkg::vrlos_sts_t sts;
    logic [1:0] margin_reg;

    // margin register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= '0;
        end else if (cfg_we) begin
            margin_reg <= cfg_data;
        end
    end

    vrlos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    vrlos_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (s_operation),
        .start_x      (s_start_x),
        .start_y      (s_start_y),
        .start_z      (s_start_z),
        .end_x        (s_end_x),
        .end_y        (s_end_y),
        .end_z        (s_end_z),
        .occupied     (s_occupied),
        .margin_val   (margin_reg),
        .m_blocked    (m_blocked),
        .m_was_query  (m_was_query)
    );

endmodule

// ----- verif/voxel_ray_line_of_sight_top_tb.sv -----
module voxel_ray_line_of_sight_top_tb;

    typedef struct {
        logic       op;
        logic [4:0] sx, sy, sz, ex, ey, ez;
        logic       occ;
    } beat_t;

    typedef struct {
        logic blocked;
        logic was_query;
    } answer_t;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic       s_operation = 0;
    logic [4:0] s_start_x = 0, s_start_y = 0, s_start_z = 0;
    logic [4:0] s_end_x = 0, s_end_y = 0, s_end_z = 0;
    logic       s_occupied = 0;
    logic       m_valid;
    logic       m_ready = 0;
    logic       m_blocked, m_was_query;
    logic       cfg_we = 0;
    logic [1:0] cfg_data = 0;

    voxel_ray_line_of_sight_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z),
        .s_occupied(s_occupied),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_blocked(m_blocked), .m_was_query(m_was_query),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    bit         occ_map [32768];
    logic [1:0] margin;

    beat_t   pending_beats[$];
    answer_t expected_answers[$];
    int      errors = 0;
    int      beats_sent = 0;
    int      answers_seen = 0;
    int      queries_blocked = 0;
    int      idle_cycles = 0;
    bit      timed_out = 0;
    bit      rx_hold = 0;
    bit      tx_pause = 0;
    bit      in_taken = 0;

    function automatic void queue_beat(beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic bit voxel_set(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x > 31 || y > 31 || z > 31) return 0;
        return occ_map[x | (y << 5) | (z << 10)];
    endfunction

    function automatic bit tube_blocked(int c[3]);
        int n[3];
        if (voxel_set(c[0], c[1], c[2])) return 1;
        for (int m = 1; m <= margin; m++) begin
            for (int a = 0; a < 3; a++) begin
                n = c;
                n[a] = c[a] + m;
                if (voxel_set(n[0], n[1], n[2])) return 1;
                n[a] = c[a] - m;
                if (voxel_set(n[0], n[1], n[2])) return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit same_cell(int p[3], int q[3]);
        return p[0] == q[0] && p[1] == q[1] && p[2] == q[2];
    endfunction

    // exact boundary comparison by cross products, zero extent means never
    function automatic bit crosses_first(int mag[3], int cnt[3], int a, int b);
        if (mag[a] == 0) return 0;
        if (mag[b] == 0) return 1;
        return (2 * cnt[a] + 1) * mag[b] < (2 * cnt[b] + 1) * mag[a];
    endfunction

    function automatic bit sight_blocked(beat_t b);
        int cur[3], fin[3], stp[3], mag[3], cnt[3], d, ax;
        cur = '{b.sx, b.sy, b.sz};
        fin = '{b.ex, b.ey, b.ez};
        if (same_cell(cur, fin)) return 0;
        for (int a = 0; a < 3; a++) begin
            d = fin[a] - cur[a];
            stp[a] = d > 0 ? 1 : (d < 0 ? -1 : 0);
            mag[a] = d < 0 ? -d : d;
            cnt[a] = 0;
        end
        while (!same_cell(cur, fin)) begin
            if (tube_blocked(cur)) return 1;
            if (crosses_first(mag, cnt, 0, 1))
                ax = crosses_first(mag, cnt, 0, 2) ? 0 : 2;
            else
                ax = crosses_first(mag, cnt, 1, 2) ? 1 : 2;
            cur[ax] += stp[ax];
            cnt[ax]++;
        end
        return voxel_set(cur[0], cur[1], cur[2]);
    endfunction

    function automatic answer_t predict_answer(beat_t b);
        answer_t r;
        if (b.op == vrlos_pkg::OP_WRITE) begin
            occ_map[int'(b.sx) | (int'(b.sy) << 5) | (int'(b.sz) << 10)] = b.occ;
            r.blocked = 0;
            r.was_query = 0;
        end else begin
            r.blocked = sight_blocked(b);
            r.was_query = 1;
        end
        return r;
    endfunction

    function automatic beat_t make_beat(logic op, int sx, int sy, int sz,
                                        int ex, int ey, int ez, logic occ);
        beat_t b;
        b.op = op; b.occ = occ;
        b.sx = 5'(sx); b.sy = 5'(sy); b.sz = 5'(sz);
        b.ex = 5'(ex); b.ey = 5'(ey); b.ez = 5'(ez);
        return b;
    endfunction

    // short rays near a cluster keep probes meaningful, some long ones too
    function automatic beat_t random_beat();
        beat_t b;
        int span;
        b.op = ($urandom_range(0, 99) < 55) ? vrlos_pkg::OP_QUERY : vrlos_pkg::OP_WRITE;
        b.occ = ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 9) == 0) begin
            {b.sx, b.sy, b.sz, b.ex, b.ey, b.ez} = 30'($urandom);
        end else begin
            span = $urandom_range(1, 6);
            b.sx = 5'(12 + $urandom_range(0, 7));
            b.sy = 5'(12 + $urandom_range(0, 7));
            b.sz = 5'(12 + $urandom_range(0, 7));
            b.ex = 5'(int'(b.sx) + $urandom_range(0, 2 * span) - span);
            b.ey = 5'(int'(b.sy) + $urandom_range(0, 2 * span) - span);
            b.ez = 5'(int'(b.sz) + $urandom_range(0, 2 * span) - span);
            if ($urandom_range(0, 3) == 0) b.occ = 0;
        end
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_answers.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    task automatic write_margin(logic [1:0] value);
        wait_drained();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 0;
        margin = value;
    endtask

    // input beat taken at this rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 0;
            end else if (!tx_pause && pending_beats.size() != 0) begin
                beat_t b;
                b = pending_beats.pop_front();
                expected_answers.insert(expected_answers.size(), predict_answer(b));
                s_valid <= 1;
                s_operation <= b.op;
                s_start_x <= b.sx; s_start_y <= b.sy; s_start_z <= b.sz;
                s_end_x <= b.ex; s_end_y <= b.ey; s_end_z <= b.ez;
                s_occupied <= b.occ;
                beats_sent++;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rx_hold) m_ready <= 0;
        else if (answers_seen % 200 < 60) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            answer_t exp_a;
            answers_seen++;
            if (expected_answers.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                exp_a = expected_answers.pop_front();
                if (m_blocked !== exp_a.blocked) begin
                    $error("blocked: expected %0b actual %0b", exp_a.blocked, m_blocked);
                    errors++;
                end
                if (m_was_query !== exp_a.was_query) begin
                    $error("was_query: expected %0b actual %0b",
                           exp_a.was_query, m_was_query);
                    errors++;
                end
                if (exp_a.was_query && exp_a.blocked) queries_blocked++;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 300000) begin
            timed_out = 1;
        end
    end

    initial begin
        wait (timed_out);
        $display("voxel_ray_line_of_sight_top_tb failed");
        $finish;
    end

    initial begin
        margin = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: obstacles, extremes, ties, equal ends, off-grid probes
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 0, 0, 0, 31, 31, 31, 1));
        queue_beat(make_beat(vrlos_pkg::OP_WRITE, 31, 31, 31, 0, 0, 0, 1));
        queue_beat(make_beat(vrlos_pkg::OP_WRITE, 0, 0, 0, 31, 31, 31, 1));
        queue_beat(make_beat(vrlos_pkg::OP_WRITE, 5, 5, 5, 0, 0, 0, 1));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 5, 5, 5, 5, 5, 5, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 0, 0, 0, 31, 31, 31, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 31, 31, 31, 0, 0, 0, 1));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 4, 4, 4, 6, 6, 6, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 4, 5, 4, 6, 5, 6, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 4, 4, 5, 6, 6, 5, 0));
        queue_beat(make_beat(vrlos_pkg::OP_WRITE, 5, 5, 5, 0, 0, 0, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 4, 4, 4, 6, 6, 6, 0));
        queue_beat(make_beat(vrlos_pkg::OP_WRITE, 0, 31, 0, 0, 0, 0, 1));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 0, 31, 0, 31, 0, 31, 1));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 1, 30, 1, 3, 30, 1, 0));
        write_margin(3);
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 3, 30, 1, 3, 26, 1, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 0, 0, 1, 0, 0, 5, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 31, 31, 30, 31, 20, 30, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 0, 0, 5, 0, 0, 0, 0));
        write_margin(1);
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 1, 1, 2, 1, 1, 8, 0));
        queue_beat(make_beat(vrlos_pkg::OP_QUERY, 2, 2, 2, 8, 8, 8, 0));
        wait_drained();

        // random phases; a new margin is written after each
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 3) begin
                // long receiver hold so the input backs up
                rx_hold = 1;
                for (int i = 0; i < 6; i++) queue_beat(random_beat());
                repeat (3000) @(posedge aclk);
                rx_hold = 0;
            end
            for (int i = 0; i < 125; i++) queue_beat(random_beat());
            if (ph == 1) begin
                // sender pauses until everything is back
                wait (pending_beats.size() < 60);
                tx_pause = 1;
                while (expected_answers.size() != 0 || s_valid) @(posedge aclk);
                tx_pause = 0;
            end
            write_margin(ph == 5 ? 2'd0 : 2'($urandom_range(0, 3)));
        end

        wait_drained();
        repeat (4000) @(posedge aclk);
        $display("covered %0d beats, %0d results, %0d blocked query answers",
                 beats_sent, answers_seen, queries_blocked);
        $display("margins 0 to 3 exercised with bursts, stalls and a long hold");
        if (errors == 0 && expected_answers.size() == 0)
            $display("voxel_ray_line_of_sight_top_tb passed");
        else
            $display("voxel_ray_line_of_sight_top_tb failed");
        $finish;
    end
endmodule

// ----- voxel_ray_line_of_sight_top.f -----
rtl/core/vrlos_pkg.sv
rtl/core/vrlos_ram.sv
rtl/core/vrlos_dp.sv
rtl/core/vrlos_ctrl.sv
rtl/core/voxel_ray_line_of_sight_top.sv
verif/voxel_ray_line_of_sight_top_tb.sv
